// ----- rtl/gtg_pkg.sv -----
// shared widths, register indexes and constants for the go-to-goal controller
`timescale 1ns / 1ps
package gtg_pkg;

   // field widths
   localparam int POS_W  = 24;
   localparam int HEAD_W = 20;
   localparam int GAIN_W = 16;
   localparam int LIN_W  = 24;
   localparam int ANG_W  = 20;
   localparam int CSR_W  = 24;
   localparam int CSR_IDX_W = 3;

   // internal widths
   localparam int DIFF_W = POS_W + 1;        // goal minus pose
   localparam int SQ_W   = 2 * POS_W + 1;    // one square
   localparam int RT_W   = 2 * DIFF_W + 1;   // root remainder and partial root
   localparam int SQ_STEPS = DIFF_W;         // one root bit per stage
   localparam int DIST_W = DIFF_W;
   localparam int CW     = 44;               // cordic x and y
   localparam int ZW     = 22;               // angle and heading error
   localparam int ATAN_LEN = 24;

   localparam int CORDIC_ITERATIONS_DEF = 16;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_GOAL_X       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_GOAL_Y       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_STEER_MODE   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_LINEAR_GAIN  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_ANGULAR_GAIN = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_HEAD_TOL     = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_ARRIVE_TOL   = 3'd6;

   // reset values
   localparam logic [GAIN_W-1:0] LINEAR_GAIN_RST  = 16'd2048;
   localparam logic [GAIN_W-1:0] ANGULAR_GAIN_RST = 16'd819;
   localparam logic [GAIN_W-1:0] HEAD_TOL_RST     = 16'd57;
   localparam logic [GAIN_W-1:0] ARRIVE_TOL_RST   = 16'd655;

   // angles in Q5.16
   localparam logic signed [ZW-1:0] Q_PI       = 22'sd205887;
   localparam logic signed [ZW-1:0] Q_HALF_PI  = 22'sd102944;
   localparam logic signed [ZW-1:0] Q_TWO_PI   = 22'sd411775;
   localparam logic signed [ZW-1:0] Q_THREE_PI = 22'sd617662;

   // rounding offset for q12 gain products
   localparam int ROUND_HALF = 2048;
   localparam int GAIN_FRAC  = 12;

   // atan(2^-i) in Q5.16
   function automatic logic signed [ZW-1:0] atan_entry(input int i);
      logic signed [ZW-1:0] v;
      case (i)
         0: v = 22'sd51472;
         1: v = 22'sd30385;
         2: v = 22'sd16055;
         3: v = 22'sd8150;
         4: v = 22'sd4091;
         5: v = 22'sd2047;
         6: v = 22'sd1024;
         7: v = 22'sd512;
         8: v = 22'sd256;
         9: v = 22'sd128;
         10: v = 22'sd64;
         11: v = 22'sd32;
         12: v = 22'sd16;
         13: v = 22'sd8;
         14: v = 22'sd4;
         15: v = 22'sd2;
         16: v = 22'sd1;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

// ----- rtl/gtg_if.sv -----
// pose and command channel interfaces
`timescale 1ns / 1ps
interface gtg_req_if import gtg_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [POS_W-1:0]  pose_x;
   logic signed [POS_W-1:0]  pose_y;
   logic signed [HEAD_W-1:0] pose_heading;

   modport source (output valid, pose_x, pose_y, pose_heading, input ready);
   modport sink (input valid, pose_x, pose_y, pose_heading, output ready);
endinterface

interface gtg_rsp_if import gtg_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [LIN_W-1:0] linear_velocity;
   logic signed [ANG_W-1:0] angular_velocity;
   logic                    stop_command;
   logic                    last_result;

   modport source (output valid, linear_velocity, angular_velocity, stop_command,
                   last_result, input ready);
   modport sink (input valid, linear_velocity, angular_velocity, stop_command,
                 last_result, output ready);
endinterface

// ----- rtl/go_to_goal_p_controller.sv -----
// go-to-goal proportional controller: root and cordic pipeline, gains, stop result
// step stages: each takes one root bit; the first CORDIC_ITERATIONS of them (at most
//   24) also take one cordic rotation, the others pass the cordic values through
// throughput: one pose beat per cycle while no result waits at the output; a sample
//   that arrives takes two output beats, and input is held until both are taken
// reset: synchronous, clears all valid bits and loads the register defaults
`timescale 1ns / 1ps
module go_to_goal_p_controller import gtg_pkg::*; #(
   parameter int CORDIC_ITERATIONS = CORDIC_ITERATIONS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   gtg_req_if.sink              req_chan,
   gtg_rsp_if.source            rsp_chan,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   localparam int NIT = (CORDIC_ITERATIONS < ATAN_LEN) ? CORDIC_ITERATIONS : ATAN_LEN;
   localparam int K   = (NIT > SQ_STEPS) ? NIT : SQ_STEPS;

   // configuration registers
   logic signed [POS_W-1:0] goal_x_ff, goal_y_ff;
   logic                    mode_ff;
   logic [GAIN_W-1:0]       lgain_ff, again_ff, htol_ff, atol_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         goal_x_ff <= '0;
         goal_y_ff <= '0;
         mode_ff   <= 1'b0;
         lgain_ff  <= LINEAR_GAIN_RST;
         again_ff  <= ANGULAR_GAIN_RST;
         htol_ff   <= HEAD_TOL_RST;
         atol_ff   <= ARRIVE_TOL_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_GOAL_X:       goal_x_ff <= csr_wdata[POS_W-1:0];
            REG_GOAL_Y:       goal_y_ff <= csr_wdata[POS_W-1:0];
            REG_STEER_MODE:   mode_ff   <= csr_wdata[0];
            REG_LINEAR_GAIN:  lgain_ff  <= csr_wdata[GAIN_W-1:0];
            REG_ANGULAR_GAIN: again_ff  <= csr_wdata[GAIN_W-1:0];
            REG_HEAD_TOL:     htol_ff   <= csr_wdata[GAIN_W-1:0];
            REG_ARRIVE_TOL:   atol_ff   <= csr_wdata[GAIN_W-1:0];
            default: ;
         endcase
      end
   end

   // global advance: the output stage can take the pipeline's last item
   logic adv;
   logic r_valid_ff, r_stop_ff, r_arr_ff;
   logic signed [LIN_W-1:0] r_lin_ff;
   logic signed [ANG_W-1:0] r_ang_ff;
   logic rsp_last;

   assign rsp_last = r_stop_ff | ~r_arr_ff;
   assign adv = ~r_valid_ff | (rsp_chan.ready & rsp_last);
   assign req_chan.ready = adv;

   // stage 0: offsets
   logic                     s0_valid_ff;
   logic signed [DIFF_W-1:0] s0_dx_ff, s0_dy_ff;
   logic signed [HEAD_W-1:0] s0_head_ff;

   always_ff @(posedge clock) begin
      if (reset) s0_valid_ff <= 1'b0;
      else if (adv) s0_valid_ff <= req_chan.valid;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s0_dx_ff   <= DIFF_W'(goal_x_ff) - DIFF_W'(req_chan.pose_x);
         s0_dy_ff   <= DIFF_W'(goal_y_ff) - DIFF_W'(req_chan.pose_y);
         s0_head_ff <= req_chan.pose_heading;
      end
   end

   // stage 1: squares and quadrant fold
   logic                     s1_valid_ff, s1_zero_ff;
   logic [SQ_W-1:0]          s1_sqx_ff, s1_sqy_ff;
   logic signed [CW-1:0]     s1_x_ff, s1_y_ff;
   logic signed [ZW-1:0]     s1_z_ff;
   logic signed [HEAD_W-1:0] s1_head_ff;
   logic signed [2*DIFF_W-1:0] sqx_full, sqy_full;
   logic signed [CW-1:0]     x_in, y_in, xs_in, ys_in;
   logic signed [ZW-1:0]     z_in;

   assign sqx_full = s0_dx_ff * s0_dx_ff;
   assign sqy_full = s0_dy_ff * s0_dy_ff;
   assign xs_in = CW'(s0_dx_ff) <<< 16;
   assign ys_in = CW'(s0_dy_ff) <<< 16;

   always_comb begin
      x_in = xs_in;
      y_in = ys_in;
      z_in = '0;
      if (s0_dx_ff < 0) begin
         if (s0_dy_ff >= 0) begin
            x_in = ys_in;
            y_in = -xs_in;
            z_in = Q_HALF_PI;
         end else begin
            x_in = -ys_in;
            y_in = xs_in;
            z_in = -Q_HALF_PI;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) s1_valid_ff <= 1'b0;
      else if (adv) s1_valid_ff <= s0_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_sqx_ff  <= sqx_full[SQ_W-1:0];
         s1_sqy_ff  <= sqy_full[SQ_W-1:0];
         s1_x_ff    <= x_in;
         s1_y_ff    <= y_in;
         s1_z_ff    <= z_in;
         s1_zero_ff <= (s0_dx_ff == 0) && (s0_dy_ff == 0);
         s1_head_ff <= s0_head_ff;
      end
   end

   // step stages: one root bit each, and one cordic rotation in each of the first NIT
   logic                     v_ff   [0:K];
   logic                     zf_ff  [0:K];
   logic signed [HEAD_W-1:0] hd_ff  [0:K];
   logic [RT_W-1:0]          rem_ff [0:K];
   logic [RT_W-1:0]          res_ff [0:K];
   logic signed [CW-1:0]     cx_ff  [0:K];
   logic signed [CW-1:0]     cy_ff  [0:K];
   logic signed [ZW-1:0]     cz_ff  [0:K];
   logic [RT_W-1:0]          rem_in [1:K];
   logic [RT_W-1:0]          res_in [1:K];
   logic signed [CW-1:0]     cx_in  [1:K];
   logic signed [CW-1:0]     cy_in  [1:K];
   logic signed [ZW-1:0]     cz_in  [1:K];

   for (genvar j = 0; j < K; j++) begin : g_step
      if (j < SQ_STEPS) begin : g_root
         localparam logic [RT_W-1:0] BITV = RT_W'(1) << (2 * (SQ_STEPS - 1 - j));
         logic [RT_W-1:0] trial;
         assign trial = res_ff[j] + BITV;
         assign rem_in[j+1] = (rem_ff[j] >= trial) ? rem_ff[j] - trial : rem_ff[j];
         assign res_in[j+1] = (rem_ff[j] >= trial) ? (res_ff[j] >> 1) + BITV
                                                   : (res_ff[j] >> 1);
      end else begin : g_root_pass
         assign rem_in[j+1] = rem_ff[j];
         assign res_in[j+1] = res_ff[j];
      end
      if (j < NIT) begin : g_rot
         logic signed [CW-1:0] xs, ys;
         assign xs = cx_ff[j] >>> j;
         assign ys = cy_ff[j] >>> j;
         assign cx_in[j+1] = (cy_ff[j] > 0) ? cx_ff[j] + ys : cx_ff[j] - ys;
         assign cy_in[j+1] = (cy_ff[j] > 0) ? cy_ff[j] - xs : cy_ff[j] + xs;
         assign cz_in[j+1] = (cy_ff[j] > 0) ? cz_ff[j] + atan_entry(j)
                                            : cz_ff[j] - atan_entry(j);
      end else begin : g_rot_pass
         assign cx_in[j+1] = cx_ff[j];
         assign cy_in[j+1] = cy_ff[j];
         assign cz_in[j+1] = cz_ff[j];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j <= K; j++) v_ff[j] <= 1'b0;
      end else if (adv) begin
         v_ff[0] <= s1_valid_ff;
         for (int j = 1; j <= K; j++) v_ff[j] <= v_ff[j-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff[0] <= RT_W'(s1_sqx_ff) + RT_W'(s1_sqy_ff);
         res_ff[0] <= '0;
         cx_ff[0]  <= s1_x_ff;
         cy_ff[0]  <= s1_y_ff;
         cz_ff[0]  <= s1_z_ff;
         zf_ff[0]  <= s1_zero_ff;
         hd_ff[0]  <= s1_head_ff;
         for (int j = 1; j <= K; j++) begin
            rem_ff[j] <= rem_in[j];
            res_ff[j] <= res_in[j];
            cx_ff[j]  <= cx_in[j];
            cy_ff[j]  <= cy_in[j];
            cz_ff[j]  <= cz_in[j];
            zf_ff[j]  <= zf_ff[j-1];
            hd_ff[j]  <= hd_ff[j-1];
         end
      end
   end

   // error stage: heading error wrapped to -pi..pi, arrival check
   logic                  e_valid_ff, e_arr_ff;
   logic signed [ZW-1:0]  e_err_ff;
   logic [DIST_W-1:0]     e_dist_ff;
   logic signed [ZW-1:0]  bear, diff, wrapped;
   logic [DIST_W-1:0]     root_dist;

   assign bear = zf_ff[K] ? '0 : cz_ff[K];
   assign diff = bear - ZW'(hd_ff[K]);
   assign root_dist = res_ff[K][DIST_W-1:0];

   always_comb begin
      if (diff > Q_THREE_PI) wrapped = diff - Q_TWO_PI - Q_TWO_PI;
      else if (diff > Q_PI) wrapped = diff - Q_TWO_PI;
      else if (diff < -Q_THREE_PI) wrapped = diff + Q_TWO_PI + Q_TWO_PI;
      else if (diff < -Q_PI) wrapped = diff + Q_TWO_PI;
      else wrapped = diff;
   end

   always_ff @(posedge clock) begin
      if (reset) e_valid_ff <= 1'b0;
      else if (adv) e_valid_ff <= v_ff[K];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         e_err_ff  <= wrapped;
         e_dist_ff <= root_dist;
         e_arr_ff  <= root_dist <= DIST_W'(atol_ff);
      end
   end

   // product stage: gains and turn decision
   localparam int LP_W = DIST_W + GAIN_W + 1;
   localparam int AP_W = ZW + GAIN_W + 1;
   logic                   p_valid_ff, p_turn_ff, p_arr_ff;
   logic signed [LP_W-1:0] p_lin_ff;
   logic signed [AP_W-1:0] p_ang_ff;
   logic [ZW-1:0]          aerr;

   assign aerr = (e_err_ff < 0) ? ZW'(-e_err_ff) : ZW'(e_err_ff);

   always_ff @(posedge clock) begin
      if (reset) p_valid_ff <= 1'b0;
      else if (adv) p_valid_ff <= e_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p_lin_ff  <= $signed({1'b0, e_dist_ff}) * $signed({1'b0, lgain_ff});
         p_ang_ff  <= e_err_ff * $signed({1'b0, again_ff});
         p_turn_ff <= aerr > ZW'(htol_ff);
         p_arr_ff  <= e_arr_ff;
      end
   end

   // output stage: round, saturate, apply steering mode; holds the stop beat
   logic signed [LP_W-1:0]  lin_rnd;
   logic signed [AP_W-1:0]  ang_rnd;
   logic signed [LIN_W-1:0] lin_sat, lin_in;
   logic signed [ANG_W-1:0] ang_sat, ang_in;
   localparam logic signed [LP_W-1:0] LIN_MAX = LP_W'((1 << (LIN_W - 1)) - 1);
   localparam logic signed [AP_W-1:0] ANG_MAX = AP_W'((1 << (ANG_W - 1)) - 1);
   localparam logic signed [AP_W-1:0] ANG_MIN = -ANG_MAX - 1;

   assign lin_rnd = (p_lin_ff + LP_W'(ROUND_HALF)) >>> GAIN_FRAC;
   assign ang_rnd = (p_ang_ff + AP_W'(ROUND_HALF)) >>> GAIN_FRAC;
   assign lin_sat = (lin_rnd > LIN_MAX) ? LIN_MAX[LIN_W-1:0] : lin_rnd[LIN_W-1:0];
   assign ang_sat = (ang_rnd > ANG_MAX) ? ANG_MAX[ANG_W-1:0] :
                    (ang_rnd < ANG_MIN) ? ANG_MIN[ANG_W-1:0] : ang_rnd[ANG_W-1:0];

   always_comb begin
      lin_in = lin_sat;
      ang_in = ang_sat;
      if (!mode_ff) begin
         if (p_turn_ff) lin_in = '0;
         else ang_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         r_valid_ff <= 1'b0;
         r_stop_ff  <= 1'b0;
      end else if (adv) begin
         r_valid_ff <= p_valid_ff;
         r_stop_ff  <= 1'b0;
      end else if (rsp_chan.ready) begin
         // first beat of an arrival taken: the stop beat follows
         r_stop_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         r_lin_ff <= lin_in;
         r_ang_ff <= ang_in;
         r_arr_ff <= p_arr_ff;
      end
   end

   assign rsp_chan.valid            = r_valid_ff;
   assign rsp_chan.linear_velocity  = r_stop_ff ? '0 : r_lin_ff;
   assign rsp_chan.angular_velocity = r_ang_ff;
   assign rsp_chan.stop_command     = r_stop_ff;
   assign rsp_chan.last_result      = rsp_last;

   // a taken non-final beat is followed by the stop beat
   a_stop_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.ready && !rsp_last |=> rsp_chan.valid && r_stop_ff)
      else $error("stop beat missing after arrival");

   // the stop beat only exists for an arrival
   a_stop_arrived: assert property (@(posedge clock) disable iff (reset)
      r_stop_ff |-> r_valid_ff && r_arr_ff)
      else $error("stop beat without arrival");

   // input is held off only while a result waits
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> r_valid_ff && !(rsp_chan.ready && rsp_last))
      else $error("pipeline stalled without a waiting result");

endmodule
